@@ sv/assert_macros.svh @@
// Assertion macros shared by the decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a property holds on every clock edge out of reset
`define MTD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition never holds out of reset
`define MTD_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/mtd_pkg.sv @@
// Types and constants for the magnetic stripe track decoder
`timescale 1ns / 1ps
package mtd_pkg;

  typedef enum logic [2:0] {
    CFG_BITS_PER_CHAR  = 3'd0,
    CFG_PARITY_INIT    = 3'd1,
    CFG_START_CODE     = 3'd2,
    CFG_SEPARATOR_CODE = 3'd3,
    CFG_END_CODE       = 3'd4,
    CFG_MAX_CODE       = 3'd5,
    CFG_ASCII_OFFSET   = 3'd6,
    CFG_MAX_CHARS      = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_START     = 3'd1,
    KIND_SEPARATOR = 3'd2,
    KIND_END       = 3'd3,
    KIND_LRC_OK    = 3'd4,
    KIND_PARITY    = 3'd5,
    KIND_BAD_CODE  = 3'd6,
    KIND_OVERFLOW  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    PHASE_WAIT_START = 2'd0,
    PHASE_WAIT_SEP   = 2'd1,
    PHASE_WAIT_END   = 2'd2,
    PHASE_WAIT_LRC   = 2'd3
  } phase_t;

  localparam int CfgDataW = 8;
  localparam int CfgIdxW  = 3;

  localparam logic [3:0] BPC_RST     = 4'd5;
  localparam logic       PARITY_RST  = 1'b1;
  localparam logic [6:0] START_RST   = 7'd11;
  localparam logic [6:0] SEP_RST     = 7'd13;
  localparam logic [6:0] END_RST     = 7'd15;
  localparam logic [6:0] MAXCODE_RST = 7'd15;
  localparam logic [7:0] OFFSET_RST  = 8'd48;
  localparam logic [6:0] MAXCHAR_RST = 7'd39;

  localparam logic [3:0]  BPC_MIN  = 4'd2;
  localparam logic [3:0]  BPC_MAX  = 4'd8;
  localparam logic [10:0] BITS_SAT = 11'd2047;

  typedef struct packed {
    logic [3:0] bits_per_char;
    logic       parity_init;
    logic [6:0] start_code;
    logic [6:0] separator_code;
    logic [6:0] end_code;
    logic [6:0] max_code;
    logic [7:0] ascii_offset;
    logic [6:0] max_chars;
  } cfg_t;

  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [7:0] ch;
  } res_t;

endpackage

@@ sv/mtd_cfg.sv @@
// Configuration register bank of the track decoder
`timescale 1ns / 1ps
module mtd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [mtd_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [mtd_pkg::CfgDataW-1:0]    cfg_wdata,
  output mtd_pkg::cfg_t                   cfg
);
  import mtd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BITS_PER_CHAR:  cfg_nxt.bits_per_char  = cfg_wdata[3:0];
        CFG_PARITY_INIT:    cfg_nxt.parity_init    = cfg_wdata[0];
        CFG_START_CODE:     cfg_nxt.start_code     = cfg_wdata[6:0];
        CFG_SEPARATOR_CODE: cfg_nxt.separator_code = cfg_wdata[6:0];
        CFG_END_CODE:       cfg_nxt.end_code       = cfg_wdata[6:0];
        CFG_MAX_CODE:       cfg_nxt.max_code       = cfg_wdata[6:0];
        CFG_ASCII_OFFSET:   cfg_nxt.ascii_offset   = cfg_wdata[7:0];
        CFG_MAX_CHARS:      cfg_nxt.max_chars      = cfg_wdata[6:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bits_per_char  <= BPC_RST;
      cfg_r.parity_init    <= PARITY_RST;
      cfg_r.start_code     <= START_RST;
      cfg_r.separator_code <= SEP_RST;
      cfg_r.end_code       <= END_RST;
      cfg_r.max_code       <= MAXCODE_RST;
      cfg_r.ascii_offset   <= OFFSET_RST;
      cfg_r.max_chars      <= MAXCHAR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/mtd_decode.sv @@
// Character assembly, parity, framing and LRC state of the track decoder
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mtd_decode #(
  parameter int MAX_BITS = 1024,
  parameter int MIN_CODE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mtd_pkg::cfg_t cfg,
  input  logic          go,
  input  logic          bit_in,
  input  logic          first_bit,
  output mtd_pkg::res_t res
);
  import mtd_pkg::*;

  localparam logic [10:0] BitLimit = 11'(MAX_BITS);
  localparam logic [6:0]  CodeMin  = 7'(MIN_CODE);

  logic [2:0]  pos_r, pos_nxt, cur_pos;
  logic [6:0]  acc_r, acc_nxt, cur_acc;
  logic        par_r, par_nxt, cur_par;
  phase_t      phase_r, phase_nxt, cur_phase;
  logic [6:0]  lrc_r, lrc_nxt, cur_lrc;
  logic [6:0]  cnt_r, cnt_nxt, cur_cnt;
  logic [10:0] tbs_r, tbs_nxt, cur_tbs;
  logic        firstc_r, firstc_nxt, cur_firstc;
  logic        halted_r, halted_nxt, cur_halted;
  logic [3:0]  bpc;
  logic [2:0]  data_bits;
  res_t        res_c;

  always_comb begin
    if (first_bit) begin
      cur_pos    = '0;
      cur_acc    = '0;
      cur_par    = cfg.parity_init;
      cur_phase  = PHASE_WAIT_START;
      cur_lrc    = '0;
      cur_cnt    = '0;
      cur_tbs    = '0;
      cur_firstc = 1'b1;
      cur_halted = 1'b0;
    end else begin
      cur_pos    = pos_r;
      cur_acc    = acc_r;
      cur_par    = par_r;
      cur_phase  = phase_r;
      cur_lrc    = lrc_r;
      cur_cnt    = cnt_r;
      cur_tbs    = tbs_r;
      cur_firstc = firstc_r;
      cur_halted = halted_r;
    end

    if (cfg.bits_per_char < BPC_MIN) begin
      bpc = BPC_MIN;
    end else if (cfg.bits_per_char > BPC_MAX) begin
      bpc = BPC_MAX;
    end else begin
      bpc = cfg.bits_per_char;
    end
    data_bits = 3'(bpc - 4'd1);

    pos_nxt    = cur_pos;
    acc_nxt    = cur_acc;
    par_nxt    = cur_par;
    phase_nxt  = cur_phase;
    lrc_nxt    = cur_lrc;
    cnt_nxt    = cur_cnt;
    tbs_nxt    = cur_tbs;
    firstc_nxt = cur_firstc;
    halted_nxt = cur_halted;
    res_c      = '0;

    if (!cur_halted) begin
      if (cur_pos == 3'd0 && cur_tbs >= BitLimit) begin
        halted_nxt = 1'b1;
      end else begin
        if (cur_tbs != BITS_SAT) begin
          tbs_nxt = cur_tbs + 11'd1;
        end
        if (cur_pos < data_bits) begin
          acc_nxt = cur_acc | (7'(bit_in) << cur_pos);
          par_nxt = cur_par ^ bit_in;
          pos_nxt = cur_pos + 3'd1;
        end else begin
          res_c.vld = 1'b1;
          if (cur_par != bit_in) begin
            res_c.kind = KIND_PARITY;
            halted_nxt = 1'b1;
          end else if (cur_acc == cfg.start_code && cur_phase == PHASE_WAIT_START
                       && cur_firstc) begin
            res_c.kind = KIND_START;
            phase_nxt  = PHASE_WAIT_SEP;
          end else if (cur_acc == cfg.separator_code && cur_phase == PHASE_WAIT_SEP) begin
            res_c.kind = KIND_SEPARATOR;
            phase_nxt  = PHASE_WAIT_END;
          end else if (cur_acc == cfg.end_code && cur_phase == PHASE_WAIT_END) begin
            res_c.kind = KIND_END;
            phase_nxt  = PHASE_WAIT_LRC;
          end else if (cur_phase == PHASE_WAIT_LRC) begin
            res_c.kind = (cur_acc == cur_lrc) ? KIND_LRC_OK : KIND_BAD_CODE;
            halted_nxt = 1'b1;
          end else if (cur_acc >= CodeMin && cur_acc <= cfg.max_code) begin
            if (cur_cnt < cfg.max_chars) begin
              res_c.kind = KIND_DATA;
              res_c.ch   = {1'b0, cur_acc} + cfg.ascii_offset;
              cnt_nxt    = cur_cnt + 7'd1;
            end else begin
              res_c.kind = KIND_OVERFLOW;
              halted_nxt = 1'b1;
            end
          end else begin
            res_c.kind = KIND_BAD_CODE;
            halted_nxt = 1'b1;
          end
          if (res_c.kind == KIND_DATA || res_c.kind == KIND_START
              || res_c.kind == KIND_SEPARATOR || res_c.kind == KIND_END) begin
            lrc_nxt = cur_lrc ^ cur_acc;
          end
          pos_nxt    = '0;
          acc_nxt    = '0;
          par_nxt    = cfg.parity_init;
          firstc_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      acc_r    <= '0;
      par_r    <= PARITY_RST;
      phase_r  <= PHASE_WAIT_START;
      lrc_r    <= '0;
      cnt_r    <= '0;
      tbs_r    <= '0;
      firstc_r <= 1'b1;
      halted_r <= 1'b0;
    end else if (go) begin
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      par_r    <= par_nxt;
      phase_r  <= phase_nxt;
      lrc_r    <= lrc_nxt;
      cnt_r    <= cnt_nxt;
      tbs_r    <= tbs_nxt;
      firstc_r <= firstc_nxt;
      halted_r <= halted_nxt;
    end
  end

  assign res = res_c;

  `MTD_NEVER(a_halted_silent, clk, rst_n, halted_r && !first_bit && res_c.vld, "result while halted")
  `MTD_ASSERT(a_halt_sticky, clk, rst_n, go && halted_r && !first_bit |=> halted_r, "halt cleared without first bit")

endmodule

@@ sv/magstripe_track_decoder_top.sv @@
// Top level of the magnetic stripe track decoder
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid in_stall in_bit_in in_first_bit | one stripe bit per word
//   out     | out_valid out_stall out_kind out_char_out | one word per character
//   cfg     | cfg_wr_en cfg_index cfg_wdata            | register writes
//
// One stripe bit per cycle while in_stall is low: a bit is held in the input register,
// and the decode logic updates the track state and loads the result register from it.
// rst_n is synchronous; it restores register defaults and clears the track state.
// in_stall rises only when a character result is ready and the result register
// still holds an untaken word; bits that complete no character pass regardless.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module magstripe_track_decoder_top #(
  parameter int MAX_BITS = 1024,
  parameter int MIN_CODE = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_bit_in,
  input  logic                         in_first_bit,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   out_kind,
  output logic [7:0]                   out_char_out,
  input  logic                         cfg_wr_en,
  input  logic [mtd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mtd_pkg::CfgDataW-1:0] cfg_wdata
);
  import mtd_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       s1_valid_r;
  logic       s1_bit_r;
  logic       s1_first_r;
  logic       out_valid_r;
  kind_t      out_kind_r;
  logic [7:0] out_char_r;
  logic       out_free;
  logic       go;
  logic       in_take;

  mtd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mtd_decode #(
    .MAX_BITS (MAX_BITS),
    .MIN_CODE (MIN_CODE)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .go        (go),
    .bit_in    (s1_bit_r),
    .first_bit (s1_first_r),
    .res       (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign go       = s1_valid_r && (!res.vld || out_free);
  assign in_stall = s1_valid_r && !go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!s1_valid_r || go) begin
        s1_valid_r <= in_take;
      end
      if (out_free) begin
        out_valid_r <= go && res.vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_bit_r   <= in_bit_in;
      s1_first_r <= in_first_bit;
    end
    if (go && res.vld) begin
      out_kind_r <= res.kind;
      out_char_r <= res.ch;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_char_out = out_char_r;

  `MTD_ASSERT(a_char_zero, clk, rst_n, out_valid_r && out_kind_r != KIND_DATA |-> out_char_r == 8'd0, "nonzero char on non-data word")
  `MTD_ASSERT(a_s1_hold, clk, rst_n, s1_valid_r && !go |=> s1_valid_r && $stable(s1_bit_r) && $stable(s1_first_r), "held bit lost")
  `MTD_NEVER(a_no_overwrite, clk, rst_n, go && res.vld && out_valid_r && out_stall, "result register overwritten")

endmodule

@@ tb/tb_magstripe_track_decoder_top.sv @@
// Self-checking testbench for the magnetic stripe track decoder top level
`timescale 1ns / 1ps
module tb_magstripe_track_decoder_top;
  import mtd_pkg::*;

  localparam int MaxBits       = 1024;
  localparam int MinCode       = 0;
  localparam int WatchdogLimit = 2000;
  localparam int AltFrom       = 12;
  localparam int ItemGoal      = 1850;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } char_word_t;

  typedef struct packed {
    logic [6:0] code;
    logic       new_swipe;
    logic       bad_par;
    logic       lrc_slot;
    logic       typed;
    kind_t      kind;
    logic [7:0] ch;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_bit_in;
  logic       in_first_bit;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_char_out;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  cfg_t        regs;
  logic [2:0]  bit_pos;
  logic [6:0]  code_acc;
  logic        par_acc;
  phase_t      frame;
  logic [6:0]  lrc_acc;
  logic [6:0]  data_cnt;
  logic [10:0] bits_seen;
  logic        first_char;
  logic        stopped;

  char_word_t pending_chars [$];
  int words_predicted = 0;
  int words_checked   = 0;
  int bits_decoded    = 0;
  int bits_sent       = 0;
  int settings_run    = 0;
  int fail_count      = 0;
  int kind_seen [8]   = '{default: 0};
  int gap_pct         = 10;
  int stall_pct       = 10;
  int stall_left      = 0;
  int idle_cycles     = 0;

  cfg_t alt_cfg = '{4'd8, 1'b0, 7'd0, 7'd127, 7'd64, 7'd100, 8'd255, 7'd1};

  row_t script [20] = '{
    '{7'd11,  1'b1, 1'b0, 1'b0, 1'b1, KIND_START,     8'd0},
    '{7'd0,   1'b0, 1'b0, 1'b0, 1'b1, KIND_DATA,      8'd48},
    '{7'd15,  1'b0, 1'b0, 1'b0, 1'b1, KIND_DATA,      8'd63},
    '{7'd11,  1'b0, 1'b0, 1'b0, 1'b0, KIND_DATA,      8'd0},
    '{7'd13,  1'b0, 1'b0, 1'b0, 1'b1, KIND_SEPARATOR, 8'd0},
    '{7'd7,   1'b0, 1'b0, 1'b0, 1'b0, KIND_DATA,      8'd0},
    '{7'd15,  1'b0, 1'b0, 1'b0, 1'b1, KIND_END,       8'd0},
    '{7'd0,   1'b0, 1'b0, 1'b1, 1'b1, KIND_LRC_OK,    8'd0},
    '{7'd3,   1'b0, 1'b0, 1'b0, 1'b0, KIND_DATA,      8'd0},
    '{7'd3,   1'b1, 1'b0, 1'b0, 1'b0, KIND_DATA,      8'd0},
    '{7'd11,  1'b0, 1'b0, 1'b0, 1'b0, KIND_DATA,      8'd0},
    '{7'd6,   1'b0, 1'b1, 1'b0, 1'b1, KIND_PARITY,    8'd0},
    '{7'd0,   1'b1, 1'b0, 1'b0, 1'b1, KIND_START,     8'd0},
    '{7'd100, 1'b0, 1'b0, 1'b0, 1'b1, KIND_DATA,      8'd99},
    '{7'd50,  1'b0, 1'b0, 1'b0, 1'b1, KIND_OVERFLOW,  8'd0},
    '{7'd127, 1'b1, 1'b0, 1'b0, 1'b1, KIND_BAD_CODE,  8'd0},
    '{7'd0,   1'b1, 1'b0, 1'b0, 1'b1, KIND_START,     8'd0},
    '{7'd127, 1'b0, 1'b0, 1'b0, 1'b1, KIND_SEPARATOR, 8'd0},
    '{7'd64,  1'b0, 1'b0, 1'b0, 1'b1, KIND_END,       8'd0},
    '{7'd1,   1'b0, 1'b0, 1'b1, 1'b1, KIND_BAD_CODE,  8'd0}
  };

  magstripe_track_decoder_top #(
    .MAX_BITS(MaxBits),
    .MIN_CODE(MinCode)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_bit_in    (in_bit_in),
    .in_first_bit (in_first_bit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_char_out (out_char_out),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int data_bits(input logic [3:0] bpc);
    if (bpc < BPC_MIN) return int'(BPC_MIN) - 1;
    if (bpc > BPC_MAX) return int'(BPC_MAX) - 1;
    return int'(bpc) - 1;
  endfunction

  function automatic void clear_track();
    bit_pos    = '0;
    code_acc   = '0;
    par_acc    = regs.parity_init;
    frame      = PHASE_WAIT_START;
    lrc_acc    = '0;
    data_cnt   = '0;
    bits_seen  = '0;
    first_char = 1'b1;
    stopped    = 1'b0;
  endfunction

  // Track decode of one stripe bit; fired marks a character word.
  function automatic void decode_bit(input logic b, input logic first_b,
                                     output logic fired, output kind_t k,
                                     output logic [7:0] c);
    logic [6:0] code;
    fired = 1'b0;
    k     = KIND_DATA;
    c     = '0;
    if (first_b) clear_track();
    if (stopped) return;
    if (bit_pos == 0 && bits_seen >= MaxBits) begin
      stopped = 1'b1;
      return;
    end
    bits_decoded++;
    if (bits_seen != BITS_SAT) bits_seen++;
    if (bit_pos < data_bits(regs.bits_per_char)) begin
      code_acc = code_acc | (7'(b) << bit_pos);
      par_acc  = par_acc ^ b;
      bit_pos  = bit_pos + 3'd1;
      return;
    end
    code = code_acc;
    if (par_acc != b) begin
      k = KIND_PARITY;
      stopped = 1'b1;
    end else if (code == regs.start_code && frame == PHASE_WAIT_START && first_char) begin
      k = KIND_START;
      frame = PHASE_WAIT_SEP;
    end else if (code == regs.separator_code && frame == PHASE_WAIT_SEP) begin
      k = KIND_SEPARATOR;
      frame = PHASE_WAIT_END;
    end else if (code == regs.end_code && frame == PHASE_WAIT_END) begin
      k = KIND_END;
      frame = PHASE_WAIT_LRC;
    end else if (frame == PHASE_WAIT_LRC) begin
      k = (code == lrc_acc) ? KIND_LRC_OK : KIND_BAD_CODE;
      stopped = 1'b1;
    end else if (int'(code) >= MinCode && code <= regs.max_code) begin
      if (data_cnt < regs.max_chars) begin
        c = 8'(code) + regs.ascii_offset;
        data_cnt = data_cnt + 7'd1;
      end else begin
        k = KIND_OVERFLOW;
        stopped = 1'b1;
      end
    end else begin
      k = KIND_BAD_CODE;
      stopped = 1'b1;
    end
    if (k <= KIND_END) lrc_acc = lrc_acc ^ code;
    bit_pos    = '0;
    code_acc   = '0;
    par_acc    = regs.parity_init;
    first_char = 1'b0;
    fired      = 1'b1;
  endfunction

  task automatic send_bit(input logic b, input logic first_b);
    int         gap;
    logic       fired;
    kind_t      k;
    logic [7:0] c;
    gap = (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_bit_in    <= b;
    in_first_bit <= first_b;
    do @(posedge clk); while (in_stall);
    bits_sent++;
    decode_bit(b, first_b, fired, k, c);
    if (fired) begin
      pending_chars.push_back({k, c});
      words_predicted++;
    end
  endtask

  task automatic send_char(input logic [6:0] code, input logic bad_par, input logic first_b);
    int d;
    d = data_bits(regs.bits_per_char);
    for (int i = 0; i < d; i++) send_bit(code[i], first_b && i == 0);
    send_bit(par_acc ^ bad_par, 1'b0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    cfg_idx_t idx;
    logic [CfgDataW-1:0] wd;
    wait_idle();
    idx = idx.first();
    do begin
      case (idx)
        CFG_BITS_PER_CHAR:  wd = {4'($urandom), c.bits_per_char};
        CFG_PARITY_INIT:    wd = {7'($urandom), c.parity_init};
        CFG_START_CODE:     wd = {1'($urandom), c.start_code};
        CFG_SEPARATOR_CODE: wd = {1'($urandom), c.separator_code};
        CFG_END_CODE:       wd = {1'($urandom), c.end_code};
        CFG_MAX_CODE:       wd = {1'($urandom), c.max_code};
        CFG_ASCII_OFFSET:   wd = c.ascii_offset;
        default:            wd = {1'($urandom), c.max_chars};
      endcase
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= wd;
      @(posedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    regs = c;
    settings_run++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic cfg_t pick_config();
    cfg_t       c;
    logic [6:0] span;
    c.bits_per_char = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(2, 8));
    span = 7'((1 << data_bits(c.bits_per_char)) - 1);
    c.parity_init    = 1'($urandom);
    c.start_code     = 7'($urandom_range(0, span));
    c.separator_code = 7'($urandom_range(0, span));
    c.end_code       = 7'($urandom_range(0, span));
    case ($urandom_range(0, 3))
      0:       c.max_code = 7'($urandom_range(0, 127));
      1:       c.max_code = 7'($urandom_range(0, span));
      default: c.max_code = span;
    endcase
    c.ascii_offset = 8'($urandom);
    case ($urandom_range(0, 9))
      0:       c.max_chars = '0;
      1, 2:    c.max_chars = 7'd127;
      3:       c.max_chars = 7'($urandom_range(1, 127));
      default: c.max_chars = 7'($urandom_range(1, 12));
    endcase
    return c;
  endfunction

  function automatic logic [6:0] pick_data(input logic [6:0] top, input logic [6:0] span);
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, span));
    return 7'($urandom_range(0, top));
  endfunction

  task automatic send_swipe();
    logic [7:0] plan [$];
    logic [6:0] span, top, code, mask;
    span = 7'((1 << data_bits(regs.bits_per_char)) - 1);
    top  = (regs.max_code < span) ? regs.max_code : span;
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 10)) plan.push_back({1'b0, 7'($urandom_range(0, span))});
    end else begin
      plan.push_back({1'b0, regs.start_code});
      repeat ($urandom_range(0, 4)) plan.push_back({1'b0, pick_data(top, span)});
      plan.push_back({1'b0, regs.separator_code});
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5))
        plan.push_back({1'b0, pick_data(top, span)});
      plan.push_back({1'b0, regs.end_code});
      mask = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(1, span)) : 7'd0;
      plan.push_back({1'b1, mask});
    end
    foreach (plan[i]) begin
      if (i > 0 && stopped && $urandom_range(0, 3) != 0) break;
      code = plan[i][7] ? (lrc_acc ^ plan[i][6:0]) : plan[i][6:0];
      send_char(code, $urandom_range(0, 39) == 0, i == 0);
    end
  endtask

  always @(negedge clk) begin
    if (stall_pct == 0) stall_left = 0;
    else if (stall_left > 0) stall_left--;
    else if ($urandom_range(1, 100) <= stall_pct)
      stall_left = $urandom_range(1, 16);
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin
    char_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      kind_seen[out_kind]++;
      if (pending_chars.size() == 0) begin
        $error("unexpected word: out_kind %0d out_char_out %0d", out_kind, out_char_out);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        words_checked++;
        if (out_kind !== want.kind) begin
          $error("out_kind mismatch: expected %0d, actual %0d", want.kind, out_kind);
          fail_count++;
        end
        if (out_char_out !== want.ch) begin
          $error("out_char_out mismatch: expected %0d, actual %0d", want.ch, out_char_out);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int         n_prior, swipes;
    bit         quiet;
    cfg_t       c;
    logic [6:0] code;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_bit_in    = 1'b0;
    in_first_bit = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_BITS_PER_CHAR;
    cfg_wdata    = '0;
    regs = '{BPC_RST, PARITY_RST, START_RST, SEP_RST, END_RST, MAXCODE_RST, OFFSET_RST,
             MAXCHAR_RST};
    clear_track();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (i == AltFrom) apply_config(alt_cfg);
      n_prior = words_predicted;
      send_char(script[i].lrc_slot ? (lrc_acc ^ script[i].code) : script[i].code,
                script[i].bad_par, script[i].new_swipe);
      if (script[i].typed) begin
        if (words_predicted != n_prior) pending_chars[$] = {script[i].kind, script[i].ch};
        else pending_chars.push_back({script[i].kind, script[i].ch});
      end
    end

    // shrink the character while it is partly received
    send_bit(1'b1, 1'b1);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b0);
    c = alt_cfg;
    c.bits_per_char = BPC_MIN;
    apply_config(c);
    send_bit(par_acc, 1'b0);

    // run one swipe into the bit budget
    c = pick_config();
    c.bits_per_char = BPC_MAX;
    c.max_code      = 7'd127;
    c.max_chars     = 7'd127;
    c.start_code    = 7'($urandom);
    c.separator_code = 7'($urandom);
    c.end_code      = 7'($urandom);
    apply_config(c);
    send_char(regs.start_code, 1'b0, 1'b1);
    send_char(regs.separator_code, 1'b0, 1'b0);
    repeat (130) begin
      code = 7'($urandom);
      if (code == regs.end_code) code = ~code;
      send_char(code, 1'b0, 1'b0);
    end

    swipes = 0;
    quiet  = 1'b0;
    while (bits_sent < ItemGoal) begin
      if (!quiet && ItemGoal - bits_sent < 250) begin
        quiet     = 1'b1;
        gap_pct   = 0;
        stall_pct = 0;
      end
      if (!quiet && swipes % 6 == 0) begin
        apply_config(pick_config());
        gap_pct   = 5 * $urandom_range(0, 3);
        stall_pct = 5 * $urandom_range(0, 3);
      end
      if (!quiet && $urandom_range(0, 29) == 0) wait_idle();
      send_swipe();
      swipes++;
    end

    wait_idle();
    $display("Covered %0d decoded stripe bits, %0d swipes, %0d register settings, %0d words checked",
             bits_decoded, swipes, settings_run, words_checked);
    $display("Kinds seen: data %0d start %0d sep %0d end %0d lrc ok %0d parity %0d bad %0d over %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4], kind_seen[5],
             kind_seen[6], kind_seen[7]);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
